// ----- sv/ir_pulse_width_receiver_macros.svh -----
// ----------------------------------------------------------------------------
// IR pulse width receiver assertion macros
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_RECEIVER_MACROS_SVH
`define IR_PULSE_WIDTH_RECEIVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IRPWR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IRPWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/irpwr_pkg.sv -----
// ----------------------------------------------------------------------------
// IR pulse width receiver package
// Widths, register indexes and reset values of the receiver.
// ----------------------------------------------------------------------------
package irpwr_pkg;

  localparam int MAX_WORD_BITS = 16;
  localparam int DUR_W         = 16;
  localparam int BITS_W        = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  typedef logic [DUR_W-1:0]         dur_t;
  typedef logic [BITS_W-1:0]        nbits_t;
  typedef logic [MAX_WORD_BITS-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARK_MIN    = 3'd0,
    REG_START_SPACE_MIN   = 3'd1,
    REG_ONE_MARK_MIN      = 3'd2,
    REG_BIT_SPACE_TIMEOUT = 3'd3,
    REG_WORD_BITS         = 3'd4
  } cfg_reg_t;

  localparam dur_t   START_MARK_MIN_RST    = 16'd1600;
  localparam dur_t   START_SPACE_MIN_RST   = 16'd1600;
  localparam dur_t   ONE_MARK_MIN_RST      = 16'd800;
  localparam dur_t   BIT_SPACE_TIMEOUT_RST = 16'd2400;
  localparam nbits_t WORD_BITS_RST         = nbits_t'(MAX_WORD_BITS);
  localparam dur_t   DUR_MAX               = '1;

endpackage

// ----- sv/ir_pulse_width_receiver.sv -----
// ----------------------------------------------------------------------------
// IR pulse width receiver
// Decodes a start frame and a word of pulse width coded bits from 1 us ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_level): one beat per 1 us tick,
//   carrying the sampled receiver pin (0 = carrier active, 1 = idle).
//   Result channel (out_valid / out_stall / out_word / out_bit_timed_out):
//   one beat per decoded word, right aligned in word_bits.
//   Config port (cfg_we / cfg_index / cfg_data): write-only thresholds and
//   word length, which the user must write only while the receiver is idle;
//   the block itself does not enforce this. An accepted tick lands in the
//   input register, and its decoded step lands in the state and result regs.
//   Throughput: one tick per cycle unless out_stall holds a pending word; the
//   per-tick update is one compare/increment pass from input to result regs.
//   Reset: thresholds return to defaults (1600/1600/800/2400, 16 bits), the
//   decoder hunts for a start mark and both registers are empty.
//   Stall: while out_stall holds a pending word, the decoder freezes on the
//   registered tick and in_stall rises; no beat is dropped.
// ----------------------------------------------------------------------------
`include "ir_pulse_width_receiver_macros.svh"

module ir_pulse_width_receiver
  import irpwr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_rx_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output word_t                 out_word,
  output logic                  out_bit_timed_out
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_START_MARK,
    PH_START_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE
  } phase_t;

  dur_t   start_mark_min_r, start_space_min_r, one_mark_min_r, bit_space_timeout_r;
  nbits_t word_bits_r;

  logic   in_vld_r, rx_r;
  phase_t phase_r, phase_nxt;
  dur_t   dur_r, dur_nxt;
  nbits_t bits_left_r, bits_left_nxt;
  word_t  shift_r, shift_nxt;
  logic   tmo_r, tmo_nxt;

  logic   out_valid_r;
  word_t  out_word_r, out_word_nxt;
  logic   out_tmo_r, out_tmo_nxt;
  logic   emit;

  logic   out_free, proc_en, active;
  dur_t   dur_inc;
  nbits_t nb_clamp, bl_dec, bl_dec2;
  word_t  sh1, sh2;

  assign out_free = !out_valid_r || !out_stall;
  assign proc_en  = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  assign active  = !rx_r;
  assign dur_inc = (dur_r == DUR_MAX) ? dur_r : dur_r + dur_t'(1);

  // Word length is sampled at each start frame, clamped to 1..MAX_WORD_BITS.
  always_comb begin
    if (word_bits_r == '0) begin
      nb_clamp = nbits_t'(1);
    end else if (word_bits_r > nbits_t'(MAX_WORD_BITS)) begin
      nb_clamp = nbits_t'(MAX_WORD_BITS);
    end else begin
      nb_clamp = word_bits_r;
    end
  end

  // Bit from a finished mark, and a possible timeout zero right behind it.
  assign bl_dec  = (bits_left_r != '0) ? bits_left_r - nbits_t'(1) : bits_left_r;
  assign bl_dec2 = (bl_dec != '0) ? bl_dec - nbits_t'(1) : bl_dec;
  assign sh1     = {shift_r[MAX_WORD_BITS-2:0], (dur_r > one_mark_min_r)};
  assign sh2     = {sh1[MAX_WORD_BITS-2:0], 1'b0};

  always_comb begin
    phase_nxt     = phase_r;
    dur_nxt       = dur_r;
    bits_left_nxt = bits_left_r;
    shift_nxt     = shift_r;
    tmo_nxt       = tmo_r;
    emit          = 1'b0;
    out_word_nxt  = shift_r;
    out_tmo_nxt   = tmo_r;
    case (phase_r)
      PH_START_MARK: begin
        if (active) begin
          dur_nxt = dur_inc;
        end else if (dur_r > start_mark_min_r) begin
          phase_nxt = PH_START_SPACE;
          dur_nxt   = dur_t'(1);
        end else begin
          phase_nxt = PH_HUNT;
          dur_nxt   = '0;
        end
      end
      PH_START_SPACE: begin
        if (!active) begin
          dur_nxt = dur_inc;
        end else if (dur_r > start_space_min_r) begin
          bits_left_nxt = nb_clamp;
          shift_nxt     = '0;
          tmo_nxt       = 1'b0;
          phase_nxt     = PH_BIT_MARK;
          dur_nxt       = dur_t'(1);
        end else begin
          phase_nxt = PH_START_MARK;
          dur_nxt   = dur_t'(1);
        end
      end
      PH_BIT_MARK: begin
        if (active) begin
          dur_nxt = dur_inc;
        end else begin
          shift_nxt     = sh1;
          bits_left_nxt = bl_dec;
          if (bl_dec == '0) begin
            emit         = 1'b1;
            out_word_nxt = sh1;
            phase_nxt    = PH_HUNT;
            dur_nxt      = '0;
          end else if (bit_space_timeout_r == '0) begin
            // first space tick already beats a zero timeout
            tmo_nxt       = 1'b1;
            shift_nxt     = sh2;
            bits_left_nxt = bl_dec2;
            dur_nxt       = '0;
            if (bl_dec2 == '0) begin
              emit         = 1'b1;
              out_word_nxt = sh2;
              out_tmo_nxt  = 1'b1;
              phase_nxt    = PH_HUNT;
            end else begin
              phase_nxt = PH_BIT_SPACE;
            end
          end else begin
            phase_nxt = PH_BIT_SPACE;
            dur_nxt   = dur_t'(1);
          end
        end
      end
      PH_BIT_SPACE: begin
        if (active) begin
          phase_nxt = PH_BIT_MARK;
          dur_nxt   = dur_t'(1);
        end else if (dur_inc > bit_space_timeout_r) begin
          tmo_nxt       = 1'b1;
          shift_nxt     = {shift_r[MAX_WORD_BITS-2:0], 1'b0};
          bits_left_nxt = bl_dec;
          dur_nxt       = '0;
          if (bl_dec == '0) begin
            emit         = 1'b1;
            out_word_nxt = {shift_r[MAX_WORD_BITS-2:0], 1'b0};
            out_tmo_nxt  = 1'b1;
            phase_nxt    = PH_HUNT;
          end
        end else begin
          dur_nxt = dur_inc;
        end
      end
      default: begin
        if (active) begin
          phase_nxt = PH_START_MARK;
          dur_nxt   = dur_t'(1);
        end else begin
          phase_nxt = PH_HUNT;
          dur_nxt   = '0;
        end
      end
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mark_min_r    <= START_MARK_MIN_RST;
      start_space_min_r   <= START_SPACE_MIN_RST;
      one_mark_min_r      <= ONE_MARK_MIN_RST;
      bit_space_timeout_r <= BIT_SPACE_TIMEOUT_RST;
      word_bits_r         <= WORD_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_MARK_MIN:    start_mark_min_r    <= cfg_data;
        REG_START_SPACE_MIN:   start_space_min_r   <= cfg_data;
        REG_ONE_MARK_MIN:      one_mark_min_r      <= cfg_data;
        REG_BIT_SPACE_TIMEOUT: bit_space_timeout_r <= cfg_data;
        REG_WORD_BITS:         word_bits_r         <= cfg_data[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      rx_r <= in_rx_level;
    end
  end

  // Decoder state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      dur_r       <= '0;
      bits_left_r <= '0;
      shift_r     <= '0;
      tmo_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (proc_en) begin
        phase_r     <= phase_nxt;
        dur_r       <= dur_nxt;
        bits_left_r <= bits_left_nxt;
        shift_r     <= shift_nxt;
        tmo_r       <= tmo_nxt;
      end
      if (out_free) begin
        out_valid_r <= proc_en && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && emit) begin
      out_word_r <= out_word_nxt;
      out_tmo_r  <= out_tmo_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_word          = out_word_r;
  assign out_bit_timed_out = out_tmo_r;

  `IRPWR_ASSERT_SAME(a_emit_from_bit_phase, proc_en && emit,
    phase_r == PH_BIT_MARK || phase_r == PH_BIT_SPACE, "word emitted outside bit phase")
  `IRPWR_ASSERT_NEXT(a_hunt_after_emit, proc_en && emit,
    phase_r == PH_HUNT && out_valid_r, "no hunt or no result after word")
  `IRPWR_ASSERT_SAME(a_bits_left_range, phase_r == PH_BIT_MARK || phase_r == PH_BIT_SPACE,
    bits_left_r != '0 && bits_left_r <= nbits_t'(MAX_WORD_BITS), "bit count out of range")
  `IRPWR_ASSERT_SAME(a_stall_cause, in_stall,
    in_vld_r && out_valid_r && out_stall, "input stalled without a held result")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse width receiver testbench
// Feeds sampled pin ticks under random idles and result stalls, runs its own
// copy of the frame decoder on every accepted beat and checks each word beat.
// ----------------------------------------------------------------------------
module tb_top;
  import irpwr_pkg::*;

  localparam int          CLK_PERIOD           = 12;
  localparam int          RESET_CYCLES         = 11;
  localparam int          IDLE_PCT             = 29;
  localparam int          DRAIN_CYCLES         = 4;
  localparam int unsigned CYCLE_LIMIT          = 1_000_000;
  localparam int          RAND_PHASES          = 8;
  localparam int          RAND_TICKS_PER_PHASE = 215;
  localparam int          RAND_WORDS_MIN       = 48;
  localparam int          LEN_CAP              = 12;

  typedef enum logic [2:0] {
    RX_HUNT, RX_START_MARK, RX_START_SPACE, RX_BIT_MARK, RX_BIT_SPACE
  } rx_phase_t;

  typedef struct packed {
    word_t word;
    logic  timed_out;
  } rx_word_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  in_rx_level = 1'b1;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  word_t                 out_word;
  logic                  out_bit_timed_out;

  // decoder copy
  rx_phase_t rx_phase;
  dur_t      rx_dur;
  nbits_t    rx_bits_left;
  word_t     rx_shift;
  logic      rx_timeout_seen;

  // register copy
  dur_t   thr_start_mark;
  dur_t   thr_start_space;
  dur_t   thr_one_mark;
  dur_t   thr_bit_timeout;
  nbits_t word_bits_reg;

  rx_word_t    words_due[$];
  rx_word_t    due_word;
  int          errors          = 0;
  int          idle_pct        = IDLE_PCT;
  int          stall_pct       = IDLE_PCT;
  int unsigned tick_count      = 0;
  int unsigned words_predicted = 0;
  int unsigned cycle_cnt       = 0;

  ir_pulse_width_receiver i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_level       (in_rx_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word          (out_word),
    .out_bit_timed_out (out_bit_timed_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still due", $time, words_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (words_due.size() == 0) begin
        $display("%0t: word beat with none due: word %h timed_out %b",
                 $time, out_word, out_bit_timed_out);
        errors++;
      end else begin
        due_word = words_due.pop_front();
        if (out_word !== due_word.word) begin
          $display("%0t: word expected %h actual %h", $time, due_word.word, out_word);
          errors++;
        end
        if (out_bit_timed_out !== due_word.timed_out) begin
          $display("%0t: bit_timed_out expected %b actual %b",
                   $time, due_word.timed_out, out_bit_timed_out);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // decoder prediction
  // --------------------------------------------------------------------------
  function automatic void reset_decoder();
    thr_start_mark  = START_MARK_MIN_RST;
    thr_start_space = START_SPACE_MIN_RST;
    thr_one_mark    = ONE_MARK_MIN_RST;
    thr_bit_timeout = BIT_SPACE_TIMEOUT_RST;
    word_bits_reg   = WORD_BITS_RST;
    rx_phase        = RX_HUNT;
    rx_dur          = '0;
    rx_bits_left    = '0;
    rx_shift        = '0;
    rx_timeout_seen = 1'b0;
  endfunction

  function automatic nbits_t clamp_bits(input nbits_t wb);
    if (wb == 0) return nbits_t'(1);
    if (wb > MAX_WORD_BITS) return nbits_t'(MAX_WORD_BITS);
    return wb;
  endfunction

  function automatic void bump_dur();
    if (rx_dur != DUR_MAX) rx_dur++;
  endfunction

  // returns 1 when the word is complete and queued
  function automatic bit shift_in_bit(input logic b);
    rx_shift = {rx_shift[MAX_WORD_BITS-2:0], b};
    if (rx_bits_left != 0) rx_bits_left--;
    if (rx_bits_left == 0) begin
      words_due.push_back('{word: rx_shift, timed_out: rx_timeout_seen});
      words_predicted++;
      rx_phase = RX_HUNT;
      rx_dur   = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void space_tick();
    if (rx_dur > thr_bit_timeout) begin
      rx_timeout_seen = 1'b1;
      rx_dur          = '0;
      void'(shift_in_bit(1'b0));
    end
  endfunction

  function automatic void decode_tick(input logic level);
    logic active;
    active = !level;
    case (rx_phase)
      RX_START_MARK: begin
        if (active) begin
          bump_dur();
        end else if (rx_dur > thr_start_mark) begin
          rx_phase = RX_START_SPACE;
          rx_dur   = dur_t'(1);
        end else begin
          rx_phase = RX_HUNT;
          rx_dur   = '0;
        end
      end
      RX_START_SPACE: begin
        if (!active) begin
          bump_dur();
        end else if (rx_dur > thr_start_space) begin
          // this active tick already belongs to the first bit's mark
          rx_bits_left    = clamp_bits(word_bits_reg);
          rx_shift        = '0;
          rx_timeout_seen = 1'b0;
          rx_phase        = RX_BIT_MARK;
          rx_dur          = dur_t'(1);
        end else begin
          rx_phase = RX_START_MARK;
          rx_dur   = dur_t'(1);
        end
      end
      RX_BIT_MARK: begin
        if (active) begin
          bump_dur();
        end else if (!shift_in_bit(rx_dur > thr_one_mark)) begin
          // the tick ending the mark is the first tick of the space
          rx_phase = RX_BIT_SPACE;
          rx_dur   = dur_t'(1);
          space_tick();
        end
      end
      RX_BIT_SPACE: begin
        if (active) begin
          rx_phase = RX_BIT_MARK;
          rx_dur   = dur_t'(1);
        end else begin
          bump_dur();
          space_tick();
        end
      end
      default: begin
        if (active) begin
          rx_phase = RX_START_MARK;
          rx_dur   = dur_t'(1);
        end else begin
          rx_phase = RX_HUNT;
          rx_dur   = '0;
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic level);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_rx_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_tick(level);
    tick_count++;
  endtask

  task automatic send_level(input logic level, input int n);
    repeat (n) send_tick(level);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_START_MARK_MIN:    thr_start_mark  = data;
      REG_START_SPACE_MIN:   thr_start_space = data;
      REG_ONE_MARK_MIN:      thr_one_mark    = data;
      REG_BIT_SPACE_TIMEOUT: thr_bit_timeout = data;
      REG_WORD_BITS:         word_bits_reg   = data[BITS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input dur_t sm, input dur_t ss, input dur_t om,
                            input dur_t bt, input nbits_t wb);
    logic [CFG_DATA_W-1:0] wb_data;
    wb_data              = CFG_DATA_W'($urandom);
    wb_data[BITS_W-1:0]  = wb;   // bits above the field are don't-care
    write_reg(REG_START_MARK_MIN, sm);
    write_reg(REG_START_SPACE_MIN, ss);
    write_reg(REG_ONE_MARK_MIN, om);
    write_reg(REG_BIT_SPACE_TIMEOUT, bt);
    write_reg(REG_WORD_BITS, wb_data);
    cfg_we <= 1'b0;
  endtask

  // sender holds off until every due word has arrived and the decoder settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_len(input int thr, input bit longer);
    int cap;
    cap = (thr > LEN_CAP) ? LEN_CAP : thr;
    if (longer) return cap + 1 + $urandom_range(3);
    return (cap == 0) ? 1 : $urandom_range(cap, 1);
  endfunction

  task automatic send_frame();
    int nb;
    nb = int'(clamp_bits(word_bits_reg));
    send_level(1'b0, pick_len(int'(thr_start_mark), $urandom_range(9) != 0));
    send_level(1'b1, pick_len(int'(thr_start_space), $urandom_range(9) != 0));
    repeat (nb) begin
      send_level(1'b0, pick_len(int'(thr_one_mark), 1'($urandom_range(1))));
      send_level(1'b1, pick_len(int'(thr_bit_timeout), $urandom_range(7) == 0));
    end
  endtask

  task automatic send_noise();
    int runs;
    runs = $urandom_range(4, 1);
    repeat (runs) send_level(1'($urandom_range(1)), $urandom_range(6, 1));
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_reset_defaults();
    // one full 16 bit word with the reset thresholds: 0x8001, timed out
    send_level(1'b0, START_MARK_MIN_RST + 1);
    send_level(1'b1, START_SPACE_MIN_RST + 1);
    send_level(1'b0, ONE_MARK_MIN_RST + 1);
    send_level(1'b1, 1);
    send_level(1'b0, ONE_MARK_MIN_RST);
    send_level(1'b1, BIT_SPACE_TIMEOUT_RST + 1);
    repeat (MAX_WORD_BITS - 4) begin
      send_level(1'b0, 1);
      send_level(1'b1, 1);
    end
    send_level(1'b0, ONE_MARK_MIN_RST + 1);
    send_level(1'b1, 1);
    wait_drained();
  endtask

  task automatic test_register_map();
    set_config(dur_t'(2), dur_t'(2), dur_t'(1), dur_t'(3), nbits_t'(2));
    @(posedge clk);
    // writes past the last register must not alias onto a real one
    for (int idx = REG_WORD_BITS + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), '0);
    cfg_we <= 1'b0;
  endtask

  task automatic test_start_framing();
    send_level(1'b0, 2);  // mark not long enough, back to hunting
    send_level(1'b1, 1);
    send_level(1'b0, 3);
    send_level(1'b1, 2);  // space too short, active starts a new mark
    send_level(1'b0, 2);
    send_level(1'b1, 3);
    send_level(1'b0, 2);  // first tick starts a new mark from hunting
    send_level(1'b1, 4);  // mark too short again, back to hunting; no word is decoded
    wait_drained();
  endtask

  task automatic test_short_word();
    write_reg(REG_WORD_BITS, '0);  // zero bits reads as one bit
    cfg_we <= 1'b0;
    send_level(1'b0, 3);
    send_level(1'b1, 3);
    send_level(1'b0, 2);
    send_level(1'b1, 1);
    wait_drained();
  endtask

  task automatic test_counter_saturation();
    idle_pct  = 0;
    stall_pct = 0;
    set_config(dur_t'(DUR_MAX - 1), '0, DUR_MAX, DUR_MAX, nbits_t'(1));
    // only a saturating counter gets past DUR_MAX - 1
    send_level(1'b0, int'(DUR_MAX) + 5);
    send_level(1'b1, 1);
    send_level(1'b0, 3);
    send_level(1'b1, 1);
    wait_drained();
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  task automatic test_random_frames();
    dur_t        sm, ss, om, bt;
    nbits_t      wb;
    int          roll;
    int unsigned ticks0;
    int unsigned words0;
    words0 = words_predicted;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      sm = dur_t'($urandom_range(10));
      ss = dur_t'($urandom_range(10));
      om = dur_t'($urandom_range(10));
      bt = dur_t'($urandom_range(10));
      wb = nbits_t'($urandom_range(MAX_WORD_BITS, 1));
      case (ph)
        1: begin
          sm = '0; ss = '0; om = '0; bt = '0; wb = nbits_t'(2);
        end
        2: begin
          om = DUR_MAX; bt = DUR_MAX; wb = '0;
        end
        3: wb = nbits_t'(MAX_WORD_BITS);
        4: wb = '1;
        5: wb = nbits_t'(MAX_WORD_BITS + 1);
        6: wb = nbits_t'(1);
        RAND_PHASES - 1: wb = nbits_t'($urandom_range(4, 1));
        default: ;
      endcase
      // one phase runs with neither idles nor stalls
      idle_pct  = (ph == 3) ? 0 : IDLE_PCT;
      stall_pct = (ph == 3) ? 0 : IDLE_PCT;
      set_config(sm, ss, om, bt, wb);
      ticks0 = tick_count;
      while (tick_count - ticks0 < RAND_TICKS_PER_PHASE ||
             (ph == RAND_PHASES - 1 && words_predicted - words0 < RAND_WORDS_MIN)) begin
        roll = $urandom_range(99);
        if (roll < 80)      send_frame();
        else if (roll < 97) send_noise();
        else                wait_drained();
      end
    end
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  initial begin
    reset_decoder();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_map();
    test_start_framing();
    test_short_word();
    test_counter_saturation();
    test_random_frames();
    wait_drained();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
